// ===== src/msu_pkg.sv =====
package msu_pkg;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    final_element;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    end_of_run;
    logic                    overflowed;
  } out_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PASS,
    ST_MERGE,
    ST_OUT
  } state_e;

endpackage

// ===== src/merge_sorter_unit.sv =====
// Merge sorter. Values arrive on the input channel, one per transfer, and are
// written into bank 0 of the element memory. The transfer whose final_element
// bit is set closes the set; the input channel then stalls until the sorted
// set has been handed to the output register.
// Sorting is a bottom-up merge sort. Each pass merges runs of width w from one
// memory bank into the other (the banks swap roles each pass), one element per
// cycle, set by the single write port of the destination bank; each pass
// opens with a setup step in ST_PASS.
// Results leave one per transfer, sorted_value ascending; end_of_run marks the
// last one and overflowed is set on every result of a set in which values
// were dropped because more than CAPACITY arrived. Each result needs a read of
// the memory, and no read is issued while the previous one is pending; a
// stall on the output channel simply holds the output register and delays
// the next read. Loading runs at one value per cycle.
// Reset clears the control state and empties the set; the memories keep
// their contents, and only entries written for the current set are read.
module merge_sorter_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  msu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output msu_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned DW = msu_pkg::DataW;

  msu_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] n_q, n_d;
  logic          sel_q, sel_d;
  logic [WW-1:0] w_q, w_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] mid_q, mid_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] ok_q, ok_d;
  logic          pend_q, pend_d;
  logic          pend_last_q, pend_last_d;
  logic          out_valid_q, out_valid_d;
  msu_pkg::out_t out_q, out_d;

  logic          in_xfer;
  logic          pass_done;
  logic          seg_end;
  logic [CW-1:0] seg_lo;
  logic [WW:0]   sum_mid;
  logic [WW:0]   sum_hi;
  logic [CW-1:0] seg_mid;
  logic [CW-1:0] seg_hi;
  logic          take_r;
  logic [DW-1:0] src_l;
  logic [DW-1:0] src_r;
  logic          load_we;
  logic          merge_we;
  logic [DW-1:0] merge_wdata;
  logic          rd_issue;

  logic          b0_we;
  logic          b1_we;
  logic [AW-1:0] b0_waddr;
  logic [DW-1:0] b0_wdata;
  logic [AW-1:0] raddr_l;
  logic [AW-1:0] raddr_r;
  logic [DW-1:0] b0_rd_l;
  logic [DW-1:0] b0_rd_r;
  logic [DW-1:0] b1_rd_l;
  logic [DW-1:0] b1_rd_r;

  assign in_xfer = in_valid_i && !in_stall_o;

  // The two banks hold the source and destination of a pass; sel_q names the
  // bank that holds the current runs.
  msu_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_bank0 (
    .clk_i     (clk_i),
    .we_i      (b0_we),
    .waddr_i   (b0_waddr),
    .wdata_i   (b0_wdata),
    .raddr_a_i (raddr_l),
    .raddr_b_i (raddr_r),
    .rdata_a_o (b0_rd_l),
    .rdata_b_o (b0_rd_r)
  );

  msu_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_bank1 (
    .clk_i     (clk_i),
    .we_i      (b1_we),
    .waddr_i   (k_q[AW-1:0]),
    .wdata_i   (merge_wdata),
    .raddr_a_i (raddr_l),
    .raddr_b_i (raddr_r),
    .rdata_a_o (b1_rd_l),
    .rdata_b_o (b1_rd_r)
  );

  assign src_l = sel_q ? b1_rd_l : b0_rd_l;
  assign src_r = sel_q ? b1_rd_r : b0_rd_r;

  // Bounds of the next run pair. A pass starts at zero; later pairs start
  // where the previous pair ended. Both bounds are clipped to the set size,
  // so a trailing lone run is merged with an empty one and just copied.
  assign seg_lo  = (state_q == msu_pkg::ST_PASS) ? '0 : hi_q;
  assign sum_mid = (WW+1)'(seg_lo) + (WW+1)'(w_q);
  assign sum_hi  = sum_mid + (WW+1)'(w_q);
  assign seg_mid = (sum_mid > (WW+1)'(n_q)) ? n_q : sum_mid[CW-1:0];
  assign seg_hi  = (sum_hi > (WW+1)'(n_q)) ? n_q : sum_hi[CW-1:0];

  assign pass_done = (w_q >= WW'(n_q));
  assign seg_end   = ((k_q + CW'(1)) == hi_q);

  // On equal values the right-hand run goes first.
  assign take_r = (i_q == mid_q) ||
                  ((j_q != hi_q) && !($signed(src_l) < $signed(src_r)));
  assign merge_wdata = take_r ? src_r : src_l;

  assign rd_issue = (state_q == msu_pkg::ST_OUT) && !pend_q &&
                    (!out_valid_q || !out_stall_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      msu_pkg::ST_LOAD: begin
        if (in_xfer && in_data_i.final_element) begin
          state_d = msu_pkg::ST_PASS;
        end
      end
      msu_pkg::ST_PASS: begin
        state_d = pass_done ? msu_pkg::ST_OUT : msu_pkg::ST_MERGE;
      end
      msu_pkg::ST_MERGE: begin
        if (seg_end && (hi_q == n_q)) begin
          state_d = msu_pkg::ST_PASS;
        end
      end
      msu_pkg::ST_OUT: begin
        if (pend_q && pend_last_q) begin
          state_d = msu_pkg::ST_LOAD;
        end
      end
      default: state_d = msu_pkg::ST_LOAD;
    endcase
  end

  // State-decoded outputs. The input is open only while loading, so a
  // write during loading needs only the valid and room in the set.
  always_comb begin
    in_stall_o = 1'b1;
    load_we    = 1'b0;
    merge_we   = 1'b0;
    case (state_q)
      msu_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        load_we    = in_valid_i && (cnt_q < CW'(CAPACITY));
      end
      msu_pkg::ST_MERGE: merge_we = 1'b1;
      default: ;
    endcase
  end

  // Datapath and counters.
  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    sel_d       = sel_q;
    w_d         = w_q;
    i_d         = i_q;
    j_d         = j_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    k_d         = k_q;
    ok_d        = ok_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    case (state_q)
      msu_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (cnt_q < CW'(CAPACITY)) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.final_element) begin
            n_d   = cnt_d;
            w_d   = WW'(1);
            sel_d = 1'b0;
          end
        end
      end
      msu_pkg::ST_PASS: begin
        if (pass_done) begin
          ok_d = '0;
        end else begin
          i_d   = '0;
          mid_d = seg_mid;
          j_d   = seg_mid;
          hi_d  = seg_hi;
          k_d   = '0;
        end
      end
      msu_pkg::ST_MERGE: begin
        k_d = k_q + CW'(1);
        if (take_r) begin
          j_d = j_q + CW'(1);
        end else begin
          i_d = i_q + CW'(1);
        end
        if (seg_end) begin
          if (hi_q == n_q) begin
            sel_d = !sel_q;
            w_d   = w_q << 1;
          end else begin
            i_d   = seg_lo;
            mid_d = seg_mid;
            j_d   = seg_mid;
            hi_d  = seg_hi;
          end
        end
      end
      msu_pkg::ST_OUT: begin
        if (rd_issue) begin
          pend_d      = 1'b1;
          ok_d        = ok_q + CW'(1);
          pend_last_d = ((ok_q + CW'(1)) == n_q);
        end
        if (pend_q && pend_last_q) begin
          cnt_d = '0;
          ovf_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Reads of the merge are addressed with the next pointers, so the data of
  // the current run heads is on the read ports in every merge cycle.
  assign raddr_l = (state_q == msu_pkg::ST_OUT) ? ok_q[AW-1:0] : i_d[AW-1:0];
  assign raddr_r = j_d[AW-1:0];

  assign b0_we    = load_we || (merge_we && sel_q);
  assign b1_we    = merge_we && !sel_q;
  assign b0_waddr = load_we ? cnt_q[AW-1:0] : k_q[AW-1:0];
  assign b0_wdata = load_we ? DW'(in_data_i.value) : merge_wdata;

  // Output register: a read is issued only when the register is free by the
  // time its data arrives.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (pend_q) begin
      out_valid_d        = 1'b1;
      out_d.sorted_value = $signed(src_l);
      out_d.end_of_run   = pend_last_q;
      out_d.overflowed   = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msu_pkg::ST_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    sel_q       <= sel_d;
    w_q         <= w_d;
    i_q         <= i_d;
    j_q         <= j_d;
    mid_q       <= mid_d;
    hi_q        <= hi_d;
    k_q         <= k_d;
    ok_q        <= ok_d;
    pend_last_q <= pend_last_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/msu_ram.sv =====
module msu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== src/msu_checker.sv =====
module msu_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input msu_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input msu_pkg::out_t out_data_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The set closes with the final element; no input is taken while it sorts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.final_element |=> in_stall_o)
    else $error("input taken right after final element");

  // While a burst is still being delivered, the input stays stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.end_of_run |-> in_stall_o)
    else $error("input open in the middle of a burst");

  // After the last result of a burst is taken, no result follows at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.end_of_run |=> !out_valid_o)
    else $error("result right after end of run");

endmodule

bind merge_sorter_unit msu_checker u_msu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
